[rtl/pmes_pkg.sv]
// ----------------------------------------------------------------------------
// pmes_pkg
// Shared types and constants of the point-mass Euler step core.
// ----------------------------------------------------------------------------
package pmes_pkg;

	// configuration register map
	localparam int unsigned REG_COUNT = 5;
	localparam int unsigned REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_USE_GRAVITY    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GRAVITY_Y      = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INVERSE_MASS   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MAX_FALL_SPEED = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FRICTION_SCALE = 3'd4;

	// integer parts of the reset values
	localparam int unsigned GRAVITY_MAG  = 2943;
	localparam int unsigned MAX_FALL_MAG = 1000;

	// datapath operations, one product each
	typedef enum logic [3:0] {
		OP_AX,
		OP_AY,
		OP_AZ,
		OP_VX,
		OP_VY,
		OP_VZ,
		OP_FA,
		OP_FS,
		OP_PX,
		OP_PY,
		OP_PZ
	} op_t;

	typedef struct packed {
		logic load;
		logic start;
		logic wb;
		logic fin;
		op_t  op;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic fric_en;
		logic out_free;
	} dp_status_t;

endpackage

[rtl/pmes_if.sv]
// ----------------------------------------------------------------------------
// pmes_if
// Item channels of the point-mass Euler step core: frame in, result out.
// ----------------------------------------------------------------------------
interface pmes_frame_if #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [WORD_WIDTH-1:0] force_x;
	logic signed [WORD_WIDTH-1:0] force_y;
	logic signed [WORD_WIDTH-1:0] force_z;
	logic                         on_ground;
	logic        [FRAC_BITS-1:0]  frame_time;
	logic signed [WORD_WIDTH-1:0] pos_x_in;
	logic signed [WORD_WIDTH-1:0] pos_y_in;
	logic signed [WORD_WIDTH-1:0] pos_z_in;

	modport source (
		output valid, force_x, force_y, force_z, on_ground, frame_time,
		       pos_x_in, pos_y_in, pos_z_in,
		input  ready
	);
	modport sink (
		input  valid, force_x, force_y, force_z, on_ground, frame_time,
		       pos_x_in, pos_y_in, pos_z_in,
		output ready
	);
endinterface

interface pmes_result_if #(
	parameter int WORD_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [WORD_WIDTH-1:0] pos_x_out;
	logic signed [WORD_WIDTH-1:0] pos_y_out;
	logic signed [WORD_WIDTH-1:0] pos_z_out;
	logic signed [WORD_WIDTH-1:0] vel_x_out;
	logic signed [WORD_WIDTH-1:0] vel_y_out;
	logic signed [WORD_WIDTH-1:0] vel_z_out;

	modport source (
		output valid, pos_x_out, pos_y_out, pos_z_out, vel_x_out, vel_y_out, vel_z_out,
		input  ready
	);
	modport sink (
		input  valid, pos_x_out, pos_y_out, pos_z_out, vel_x_out, vel_y_out, vel_z_out,
		output ready
	);
endinterface

[rtl/pmes_cfg.sv]
// ----------------------------------------------------------------------------
// pmes_cfg
// APB-style configuration registers.
// ----------------------------------------------------------------------------
module pmes_cfg #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	parameter int DATA_W     = 32,
	parameter int ADDR_W     = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic        [ADDR_W-1:0]     paddr,
	input  logic        [DATA_W-1:0]     pwdata,
	output logic        [DATA_W-1:0]     prdata,
	output logic                         pready,
	output logic                         use_gravity,
	output logic signed [WORD_WIDTH-1:0] gravity_y,
	output logic        [WORD_WIDTH-1:0] inverse_mass,
	output logic        [WORD_WIDTH-2:0] max_fall_speed,
	output logic        [WORD_WIDTH-2:0] friction_scale
);

	localparam int ALIGN = ADDR_W - pmes_pkg::REG_IDX_W;

	localparam logic [WORD_WIDTH-1:0] GRAV_MAG =
		WORD_WIDTH'(64'(pmes_pkg::GRAVITY_MAG) << FRAC_BITS);
	localparam logic [WORD_WIDTH-1:0] INV_RST  = WORD_WIDTH'(64'(1) << FRAC_BITS);
	localparam logic [WORD_WIDTH-2:0] MAXF_RST =
		(WORD_WIDTH-1)'(64'(pmes_pkg::MAX_FALL_MAG) << FRAC_BITS);

	logic                         use_gravity_q;
	logic        [WORD_WIDTH-1:0] gravity_y_q;
	logic        [WORD_WIDTH-1:0] inverse_mass_q;
	logic        [WORD_WIDTH-2:0] max_fall_speed_q;
	logic        [WORD_WIDTH-2:0] friction_scale_q;
	logic [pmes_pkg::REG_IDX_W-1:0] idx;
	logic                           wr;

	assign idx    = paddr[ADDR_W-1:ALIGN];
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_gravity_q    <= 1'b1;
			gravity_y_q      <= WORD_WIDTH'(0) - GRAV_MAG;
			inverse_mass_q   <= INV_RST;
			max_fall_speed_q <= MAXF_RST;
			friction_scale_q <= '0;
		end else if (wr) begin
			case (idx)
				pmes_pkg::REG_USE_GRAVITY:    use_gravity_q    <= pwdata[0];
				pmes_pkg::REG_GRAVITY_Y:      gravity_y_q      <= pwdata[WORD_WIDTH-1:0];
				pmes_pkg::REG_INVERSE_MASS:   inverse_mass_q   <= pwdata[WORD_WIDTH-1:0];
				pmes_pkg::REG_MAX_FALL_SPEED: max_fall_speed_q <= pwdata[WORD_WIDTH-2:0];
				pmes_pkg::REG_FRICTION_SCALE: friction_scale_q <= pwdata[WORD_WIDTH-2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			pmes_pkg::REG_USE_GRAVITY:    prdata = DATA_W'(use_gravity_q);
			pmes_pkg::REG_GRAVITY_Y:      prdata = DATA_W'(gravity_y_q);
			pmes_pkg::REG_INVERSE_MASS:   prdata = DATA_W'(inverse_mass_q);
			pmes_pkg::REG_MAX_FALL_SPEED: prdata = DATA_W'(max_fall_speed_q);
			pmes_pkg::REG_FRICTION_SCALE: prdata = DATA_W'(friction_scale_q);
			default:                      prdata = '0;
		endcase
	end

	assign use_gravity    = use_gravity_q;
	assign gravity_y      = $signed(gravity_y_q);
	assign inverse_mass   = inverse_mass_q;
	assign max_fall_speed = max_fall_speed_q;
	assign friction_scale = friction_scale_q;

endmodule

[rtl/pmes_mul.sv]
// ----------------------------------------------------------------------------
// pmes_mul
// Shared multiplier: signed word times unsigned word, one digit of the
// unsigned operand per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module pmes_mul #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [WORD_WIDTH-1:0]   a,
	input  logic        [WORD_WIDTH-1:0]   b,
	output logic                           done,
	output logic signed [2*WORD_WIDTH-1:0] prod
);

	localparam int ND    = (WORD_WIDTH + 31) / 32;
	localparam int DIG_W = (WORD_WIDTH + ND - 1) / ND;
	localparam int BW    = ND * DIG_W;
	localparam int AW    = WORD_WIDTH + BW;
	localparam int PT_W  = WORD_WIDTH + DIG_W + 1;
	localparam int CW    = $clog2(ND + 1);

	logic signed [WORD_WIDTH-1:0] a_q;
	logic        [BW-1:0]         b_q;
	logic signed [AW-1:0]         acc_q;
	logic        [CW-1:0]         cnt_q;
	logic                         done_q;

	logic        [BW-1:0]         b_pad;
	logic signed [WORD_WIDTH-1:0] a_sel;
	logic        [DIG_W-1:0]      dig;
	logic signed [PT_W-1:0]       partial;
	logic signed [AW-1:0]         acc_base;
	logic signed [AW-1:0]         acc_next;

	assign b_pad = BW'(b);

	always_comb begin
		a_sel    = start ? a : a_q;
		dig      = start ? b_pad[BW-1 -: DIG_W] : b_q[BW-1 -: DIG_W];
		partial  = a_sel * $signed({1'b0, dig});
		acc_base = start ? AW'(0) : (acc_q <<< DIG_W);
		acc_next = acc_base + AW'(partial);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b_pad << DIG_W;
			acc_q <= acc_next;
		end else if (cnt_q != '0) begin
			b_q   <= b_q << DIG_W;
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(ND - 1);
			done_q <= (ND == 1);
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign prod = acc_q[2*WORD_WIDTH-1:0];

endmodule

[rtl/pmes_dp.sv]
// ----------------------------------------------------------------------------
// pmes_dp
// Datapath: operand selection, shared multiplier, saturating write-back,
// velocity state and result registers.
// ----------------------------------------------------------------------------
module pmes_dp #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pmes_pkg::dp_cmd_t            cmd,
	output pmes_pkg::dp_status_t         status,
	input  logic                         use_gravity,
	input  logic signed [WORD_WIDTH-1:0] gravity_y,
	input  logic        [WORD_WIDTH-1:0] inverse_mass,
	input  logic        [WORD_WIDTH-2:0] max_fall_speed,
	input  logic        [WORD_WIDTH-2:0] friction_scale,
	input  logic signed [WORD_WIDTH-1:0] force_x,
	input  logic signed [WORD_WIDTH-1:0] force_y,
	input  logic signed [WORD_WIDTH-1:0] force_z,
	input  logic                         on_ground,
	input  logic        [FRAC_BITS-1:0]  frame_time,
	input  logic signed [WORD_WIDTH-1:0] pos_x_in,
	input  logic signed [WORD_WIDTH-1:0] pos_y_in,
	input  logic signed [WORD_WIDTH-1:0] pos_z_in,
	input  logic                         result_ready,
	output logic                         result_valid,
	output logic signed [WORD_WIDTH-1:0] pos_x_out,
	output logic signed [WORD_WIDTH-1:0] pos_y_out,
	output logic signed [WORD_WIDTH-1:0] pos_z_out,
	output logic signed [WORD_WIDTH-1:0] vel_x_out,
	output logic signed [WORD_WIDTH-1:0] vel_y_out,
	output logic signed [WORD_WIDTH-1:0] vel_z_out
);

	localparam int W = WORD_WIDTH;
	localparam int F = FRAC_BITS;
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	function automatic logic signed [W-1:0] sat_add(logic signed [W-1:0] x,
		logic signed [W-1:0] y);
		logic signed [W:0] s;
		s = {x[W-1], x} + {y[W-1], y};
		if (s[W] != s[W-1])
			return s[W] ? MINV : MAXV;
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] mag(logic signed [W-1:0] x);
		return x[W-1] ? W'(0) - x : x;
	endfunction

	// accel holds the force until its own product is written back;
	// lane x then holds the friction acceleration for the velocity step
	logic signed [W-1:0] acc_q [3];
	logic signed [W-1:0] pos_q [3];
	logic signed [W-1:0] vel_q [3];
	logic signed [W-1:0] pos_out_q [3];
	logic signed [W-1:0] vel_out_q [3];
	logic        [F-1:0] dt_q;
	logic                ground_q;
	logic                zero_force_q;
	logic                out_valid_q;

	logic signed [W-1:0]   mul_a;
	logic        [W-1:0]   mul_b;
	logic                  mul_done;
	logic signed [2*W-1:0] prod;
	logic        [W-F:0]   prod_top;
	logic signed [W-1:0]   q;
	logic signed [W-1:0]   fric_force;
	logic signed [W-1:0]   ay_wb;
	logic signed [W-1:0]   vy_sum;
	logic signed [W-1:0]   vy_wb;
	logic signed [W-1:0]   vx_fs;
	logic signed [W-1:0]   max_fall;

	pmes_mul #(
		.WORD_WIDTH (W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (prod)
	);

	// product >> F, floor, saturated
	assign prod_top = prod[2*W-1:F+W-1];
	always_comb begin
		if (&prod_top || ~|prod_top)
			q = prod[F+W-1:F];
		else
			q = prod[2*W-1] ? MINV : MAXV;
	end

	assign max_fall   = $signed({1'b0, max_fall_speed});
	assign fric_force = (!vel_q[0][W-1] && vel_q[0] != '0) ?
		-$signed({1'b0, friction_scale}) : $signed({1'b0, friction_scale});

	always_comb begin
		mul_a = acc_q[0];
		mul_b = inverse_mass;
		case (cmd.op)
			pmes_pkg::OP_AX: begin mul_a = acc_q[0];   mul_b = inverse_mass; end
			pmes_pkg::OP_AY: begin mul_a = acc_q[1];   mul_b = inverse_mass; end
			pmes_pkg::OP_AZ: begin mul_a = acc_q[2];   mul_b = inverse_mass; end
			pmes_pkg::OP_VX: begin mul_a = acc_q[0];   mul_b = W'(dt_q); end
			pmes_pkg::OP_VY: begin mul_a = acc_q[1];   mul_b = W'(dt_q); end
			pmes_pkg::OP_VZ: begin mul_a = acc_q[2];   mul_b = W'(dt_q); end
			pmes_pkg::OP_FA: begin mul_a = fric_force; mul_b = inverse_mass; end
			pmes_pkg::OP_FS: begin mul_a = acc_q[0];   mul_b = W'(dt_q); end
			pmes_pkg::OP_PX: begin mul_a = vel_q[0];   mul_b = W'(dt_q); end
			pmes_pkg::OP_PY: begin mul_a = vel_q[1];   mul_b = W'(dt_q); end
			pmes_pkg::OP_PZ: begin mul_a = vel_q[2];   mul_b = W'(dt_q); end
			default: begin mul_a = acc_q[0]; mul_b = inverse_mass; end
		endcase
	end

	always_comb begin
		if (!use_gravity)
			ay_wb = q;
		else if (ground_q)
			ay_wb = '0;
		else
			ay_wb = sat_add(q, gravity_y);

		vy_sum = sat_add(vel_q[1], q);
		if (!ground_q && mag(vy_sum) > W'(max_fall_speed))
			vy_wb = vy_sum[W-1] ? -max_fall : max_fall;
		else
			vy_wb = vy_sum;

		// friction stops at zero rather than reversing
		if (mag(vel_q[0]) < mag(q))
			vx_fs = '0;
		else
			vx_fs = sat_add(vel_q[0], q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q[0]     <= force_x;
			acc_q[1]     <= force_y;
			acc_q[2]     <= force_z;
			pos_q[0]     <= pos_x_in;
			pos_q[1]     <= pos_y_in;
			pos_q[2]     <= pos_z_in;
			dt_q         <= frame_time;
			ground_q     <= on_ground;
			zero_force_q <= (force_x == '0) && (force_y == '0) && (force_z == '0);
		end else if (cmd.wb) begin
			case (cmd.op)
				pmes_pkg::OP_AX: acc_q[0] <= q;
				pmes_pkg::OP_AY: acc_q[1] <= ay_wb;
				pmes_pkg::OP_AZ: acc_q[2] <= q;
				pmes_pkg::OP_FA: acc_q[0] <= q;
				pmes_pkg::OP_PX: pos_q[0] <= sat_add(pos_q[0], q);
				pmes_pkg::OP_PY: pos_q[1] <= sat_add(pos_q[1], q);
				pmes_pkg::OP_PZ: pos_q[2] <= sat_add(pos_q[2], q);
				default: ;
			endcase
		end
		if (cmd.fin) begin
			pos_out_q <= pos_q;
			vel_out_q <= vel_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_q[0]    <= '0;
			vel_q[1]    <= '0;
			vel_q[2]    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.wb) begin
				case (cmd.op)
					pmes_pkg::OP_VX: vel_q[0] <= sat_add(vel_q[0], q);
					pmes_pkg::OP_VY: vel_q[1] <= vy_wb;
					pmes_pkg::OP_VZ: vel_q[2] <= sat_add(vel_q[2], q);
					pmes_pkg::OP_FS: vel_q[0] <= vx_fs;
					default: ;
				endcase
			end
			if (cmd.fin)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign status.mul_done = mul_done;
	assign status.fric_en  = zero_force_q & ground_q & (vel_q[0] != '0);
	assign status.out_free = !out_valid_q || result_ready;

	assign result_valid = out_valid_q;
	assign pos_x_out    = pos_out_q[0];
	assign pos_y_out    = pos_out_q[1];
	assign pos_z_out    = pos_out_q[2];
	assign vel_x_out    = vel_out_q[0];
	assign vel_y_out    = vel_out_q[1];
	assign vel_z_out    = vel_out_q[2];

endmodule

[rtl/pmes_ctrl.sv]
// ----------------------------------------------------------------------------
// pmes_ctrl
// Controller: steps the datapath through the products of one item.
// ----------------------------------------------------------------------------
module pmes_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pmes_pkg::dp_status_t status,
	output pmes_pkg::dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_FIN
	} state_t;

	state_t           state_q;
	pmes_pkg::op_t    op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= pmes_pkg::OP_AX;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ISSUE;
						op_q    <= pmes_pkg::OP_AX;
					end
				end
				S_ISSUE: state_q <= S_WAIT;
				S_WAIT: begin
					if (status.mul_done) begin
						state_q <= (op_q < pmes_pkg::OP_PZ) ? S_ISSUE : S_FIN;
						case (op_q)
							pmes_pkg::OP_AX: op_q <= pmes_pkg::OP_AY;
							pmes_pkg::OP_AY: op_q <= pmes_pkg::OP_AZ;
							pmes_pkg::OP_AZ: op_q <= pmes_pkg::OP_VX;
							pmes_pkg::OP_VX: op_q <= pmes_pkg::OP_VY;
							pmes_pkg::OP_VY: op_q <= pmes_pkg::OP_VZ;
							pmes_pkg::OP_VZ: op_q <= status.fric_en ? pmes_pkg::OP_FA
							                                        : pmes_pkg::OP_PX;
							pmes_pkg::OP_FA: op_q <= pmes_pkg::OP_FS;
							pmes_pkg::OP_FS: op_q <= pmes_pkg::OP_PX;
							pmes_pkg::OP_PX: op_q <= pmes_pkg::OP_PY;
							pmes_pkg::OP_PY: op_q <= pmes_pkg::OP_PZ;
							pmes_pkg::OP_PZ: op_q <= pmes_pkg::OP_AX;
							default:         op_q <= pmes_pkg::OP_AX;
						endcase
					end
				end
				S_FIN: begin
					if (status.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cmd.load  = (state_q == S_IDLE) & in_valid;
	assign cmd.start = (state_q == S_ISSUE);
	assign cmd.wb    = (state_q == S_WAIT) & status.mul_done;
	assign cmd.fin   = (state_q == S_FIN) & status.out_free;
	assign cmd.op    = op_q;

endmodule

[rtl/point_mass_euler_step_core.sv]
// ----------------------------------------------------------------------------
// point_mass_euler_step_core
// Semi-implicit Euler step of a point mass with gravity, fall-speed clamp
// and ground friction, saturating signed fixed point.
// ----------------------------------------------------------------------------
// One frame item is taken, then the products of the step run one after the
// other on a single shared multiplier: force times inverse mass on three
// axes, acceleration times frame time, the two friction products when the
// body is grounded with no force and moving in x, and velocity times frame
// time: nine products, or eleven when friction applies. The next item is
// taken as soon as the result is in the output register, which holds it
// until it is taken. Velocity is kept between items and resets to zero.
// ----------------------------------------------------------------------------
module point_mass_euler_step_core #(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 16,
	localparam int DATA_W    = (WORD_WIDTH > 32) ? 64 : 32,
	localparam int ADDR_W    = pmes_pkg::REG_IDX_W + ((WORD_WIDTH > 32) ? 3 : 2)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	pmes_frame_if.sink          frame,
	pmes_result_if.source       result
);

	logic                         use_gravity;
	logic signed [WORD_WIDTH-1:0] gravity_y;
	logic        [WORD_WIDTH-1:0] inverse_mass;
	logic        [WORD_WIDTH-2:0] max_fall_speed;
	logic        [WORD_WIDTH-2:0] friction_scale;
	pmes_pkg::dp_cmd_t            cmd;
	pmes_pkg::dp_status_t         status;

	pmes_cfg #(
		.WORD_WIDTH (WORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.DATA_W     (DATA_W),
		.ADDR_W     (ADDR_W)
	) u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.use_gravity    (use_gravity),
		.gravity_y      (gravity_y),
		.inverse_mass   (inverse_mass),
		.max_fall_speed (max_fall_speed),
		.friction_scale (friction_scale)
	);

	pmes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (frame.valid),
		.in_ready (frame.ready),
		.status   (status),
		.cmd      (cmd)
	);

	pmes_dp #(
		.WORD_WIDTH (WORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.use_gravity    (use_gravity),
		.gravity_y      (gravity_y),
		.inverse_mass   (inverse_mass),
		.max_fall_speed (max_fall_speed),
		.friction_scale (friction_scale),
		.force_x        (frame.force_x),
		.force_y        (frame.force_y),
		.force_z        (frame.force_z),
		.on_ground      (frame.on_ground),
		.frame_time     (frame.frame_time),
		.pos_x_in       (frame.pos_x_in),
		.pos_y_in       (frame.pos_y_in),
		.pos_z_in       (frame.pos_z_in),
		.result_ready   (result.ready),
		.result_valid   (result.valid),
		.pos_x_out      (result.pos_x_out),
		.pos_y_out      (result.pos_y_out),
		.pos_z_out      (result.pos_z_out),
		.vel_x_out      (result.vel_x_out),
		.vel_y_out      (result.vel_y_out),
		.vel_z_out      (result.vel_z_out)
	);

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the point-mass Euler step core. Frame items go in
// through a valid/ready channel with random gaps. Results are taken with
// random back-pressure and compared with a fixed-point motion predictor that
// keeps its own velocity and register copies. A directed run covers the
// friction, clamp, gravity and saturation corners. Random phases with fresh
// register settings follow.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int WW     = 32;
	localparam int FB     = 16;
	localparam int IDX_W  = pmes_pkg::REG_IDX_W;
	localparam int ADDR_W = IDX_W + 2;

	localparam longint WORD_MAX = (longint'(1) << (WW - 1)) - 1;
	localparam longint WORD_MIN = -WORD_MAX - 1;

	localparam logic [IDX_W-1:0] REG_SPARE_FIRST = IDX_W'(pmes_pkg::REG_COUNT);
	localparam logic [IDX_W-1:0] REG_SPARE_LAST  = {IDX_W{1'b1}};

	typedef logic signed [WW-1:0] word_t;

	typedef struct {
		word_t         force_x;
		word_t         force_y;
		word_t         force_z;
		logic          on_ground;
		logic [FB-1:0] frame_time;
		word_t         pos_x;
		word_t         pos_y;
		word_t         pos_z;
	} frame_item_t;

	typedef struct {
		word_t pos_x;
		word_t pos_y;
		word_t pos_z;
		word_t vel_x;
		word_t vel_y;
		word_t vel_z;
	} step_result_t;

	class motion_scoreboard;
		bit           gravity_on;
		longint       gravity_y;
		longint       inv_mass;
		longint       fall_limit;
		longint       friction;
		longint       vel_x;
		longint       vel_y;
		longint       vel_z;
		step_result_t expected_steps[$];
		int unsigned  mismatches;

		function new();
			gravity_on = 1'b1;
			gravity_y  = -(longint'(pmes_pkg::GRAVITY_MAG) << FB);
			inv_mass   = longint'(1) << FB;
			fall_limit = longint'(pmes_pkg::MAX_FALL_MAG) << FB;
			friction   = 0;
			vel_x      = 0;
			vel_y      = 0;
			vel_z      = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [31:0] value);
			case (idx)
				pmes_pkg::REG_USE_GRAVITY:    gravity_on = value[0];
				pmes_pkg::REG_GRAVITY_Y:      gravity_y  = longint'($signed(value));
				pmes_pkg::REG_INVERSE_MASS:   inv_mass   = longint'(value);
				pmes_pkg::REG_MAX_FALL_SPEED: fall_limit = longint'(value[30:0]);
				pmes_pkg::REG_FRICTION_SCALE: friction   = longint'(value[30:0]);
				default: ;
			endcase
		endfunction

		function longint clamp(logic signed [127:0] v);
			if (v > WORD_MAX)
				return WORD_MAX;
			if (v < WORD_MIN)
				return WORD_MIN;
			return longint'(v);
		endfunction

		// floor of the product shifted down by the fraction bits
		function longint fixed_mul(longint a, longint b);
			logic signed [127:0] wa;
			logic signed [127:0] wb;
			wa = a;
			wb = b;
			return clamp((wa * wb) >>> FB);
		endfunction

		function longint magnitude(longint v);
			return (v < 0) ? -v : v;
		endfunction

		function void note_frame(frame_item_t it);
			longint       ax;
			longint       ay;
			longint       az;
			longint       dt;
			longint       drag;
			longint       dv;
			step_result_t r;
			dt = longint'(it.frame_time);
			ax = fixed_mul(it.force_x, inv_mass);
			ay = fixed_mul(it.force_y, inv_mass);
			az = fixed_mul(it.force_z, inv_mass);
			if (gravity_on && !it.on_ground)
				ay = clamp(ay + gravity_y);
			else if (gravity_on)
				ay = 0;
			vel_x = clamp(vel_x + fixed_mul(ax, dt));
			vel_y = clamp(vel_y + fixed_mul(ay, dt));
			vel_z = clamp(vel_z + fixed_mul(az, dt));
			if (!it.on_ground && magnitude(vel_y) > fall_limit)
				vel_y = (vel_y < 0) ? -fall_limit : fall_limit;
			if (it.force_x == 0 && it.force_y == 0 && it.force_z == 0 && vel_x != 0 &&
					it.on_ground) begin
				drag = (vel_x > 0) ? -friction : friction;
				dv   = fixed_mul(fixed_mul(drag, inv_mass), dt);
				// friction stops the body instead of reversing it
				if (magnitude(vel_x) < magnitude(dv))
					vel_x = 0;
				else
					vel_x = clamp(vel_x + dv);
			end
			r.pos_x = word_t'(clamp(longint'(it.pos_x) + fixed_mul(vel_x, dt)));
			r.pos_y = word_t'(clamp(longint'(it.pos_y) + fixed_mul(vel_y, dt)));
			r.pos_z = word_t'(clamp(longint'(it.pos_z) + fixed_mul(vel_z, dt)));
			r.vel_x = word_t'(vel_x);
			r.vel_y = word_t'(vel_y);
			r.vel_z = word_t'(vel_z);
			expected_steps.push_back(r);
		endfunction

		function void compare_field(string name, word_t want, word_t got);
			if (want !== got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_step(step_result_t got);
			step_result_t want;
			if (expected_steps.size() == 0) begin
				$error("result item with no frame pending");
				mismatches++;
				return;
			end
			want = expected_steps.pop_front();
			compare_field("pos_x_out", want.pos_x, got.pos_x);
			compare_field("pos_y_out", want.pos_y, got.pos_y);
			compare_field("pos_z_out", want.pos_z, got.pos_z);
			compare_field("vel_x_out", want.vel_x, got.vel_x);
			compare_field("vel_y_out", want.vel_y, got.vel_y);
			compare_field("vel_z_out", want.vel_z, got.vel_z);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	pmes_frame_if #(.WORD_WIDTH(WW), .FRAC_BITS(FB)) frame_ch ();
	pmes_result_if #(.WORD_WIDTH(WW)) result_ch ();

	point_mass_euler_step_core #(
		.WORD_WIDTH(WW),
		.FRAC_BITS (FB)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.frame  (frame_ch),
		.result (result_ch)
	);

	motion_scoreboard sb = new();

	bit          src_idle;
	bit          snk_idle;
	int unsigned snk_hold;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("point_mass_euler_step_core verification failed");
		$finish;
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	// valid stays high between back-to-back items
	task automatic send_frame(input frame_item_t it);
		int unsigned gap;
		gap = src_idle ? $urandom_range(0, 14) : 0;
		if (gap != 0) begin
			frame_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_ch.valid      <= 1'b1;
		frame_ch.force_x    <= it.force_x;
		frame_ch.force_y    <= it.force_y;
		frame_ch.force_z    <= it.force_z;
		frame_ch.on_ground  <= it.on_ground;
		frame_ch.frame_time <= it.frame_time;
		frame_ch.pos_x_in   <= it.pos_x;
		frame_ch.pos_y_in   <= it.pos_y;
		frame_ch.pos_z_in   <= it.pos_z;
		@(posedge clk);
		while (!frame_ch.ready) @(posedge clk);
		sb.note_frame(it);
	endtask

	task automatic settle();
		frame_ch.valid <= 1'b0;
		while (sb.expected_steps.size() != 0) @(posedge clk);
	endtask

	function automatic frame_item_t mk_frame(word_t fx, word_t fy, word_t fz, logic gnd,
			logic [FB-1:0] dt, word_t px, word_t py, word_t pz);
		frame_item_t it;
		it.force_x    = fx;
		it.force_y    = fy;
		it.force_z    = fz;
		it.on_ground  = gnd;
		it.frame_time = dt;
		it.pos_x      = px;
		it.pos_y      = py;
		it.pos_z      = pz;
		return it;
	endfunction

	function automatic word_t rand_force();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return word_t'(int'($urandom_range(0, 40 << FB)) - (20 << FB));
			2: return word_t'(int'($urandom_range(0, 1 << FB)) - (1 << (FB - 1)));
			default: return word_t'($urandom);
		endcase
	endfunction

	function automatic word_t rand_pos();
		if ($urandom_range(0, 3) == 0)
			return word_t'($urandom);
		return word_t'(int'($urandom_range(0, 2000 << FB)) - (1000 << FB));
	endfunction

	function automatic frame_item_t rand_frame();
		frame_item_t it;
		it.force_x = rand_force();
		it.force_y = rand_force();
		it.force_z = rand_force();
		// force-free items let friction act
		if ($urandom_range(0, 3) == 0) begin
			it.force_x = '0;
			it.force_y = '0;
			it.force_z = '0;
		end
		it.on_ground = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 4))
			0, 1: it.frame_time = FB'($urandom_range(0, 16'h0800));
			2: it.frame_time = $urandom_range(0, 1) ? {FB{1'b1}} : '0;
			default: it.frame_time = FB'($urandom);
		endcase
		it.pos_x = rand_pos();
		it.pos_y = rand_pos();
		it.pos_z = rand_pos();
		return it;
	endfunction

	task automatic shuffle_settings();
		logic [31:0] v;
		write_reg(pmes_pkg::REG_USE_GRAVITY,
			($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(0, 1)));
		case ($urandom_range(0, 5))
			0: v = 32'(-(pmes_pkg::GRAVITY_MAG << FB));
			1: v = $urandom;
			2: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: v = 32'(-int'($urandom_range(0, 5000 << FB)));
		endcase
		write_reg(pmes_pkg::REG_GRAVITY_Y, v);
		case ($urandom_range(0, 5))
			0: v = 32'(1 << FB);
			1: v = $urandom;
			2: v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			default: v = $urandom_range(1 << (FB - 4), 4 << FB);
		endcase
		write_reg(pmes_pkg::REG_INVERSE_MASS, v);
		case ($urandom_range(0, 5))
			0: v = 32'(pmes_pkg::MAX_FALL_MAG << FB);
			1: v = $urandom;
			2: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0000_0000;
			default: v = $urandom_range(0, 2000 << FB);
		endcase
		write_reg(pmes_pkg::REG_MAX_FALL_SPEED, v);
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = $urandom;
			2: v = 32'h7FFF_FFFF;
			default: v = $urandom_range(0, 200 << FB);
		endcase
		write_reg(pmes_pkg::REG_FRICTION_SCALE, v);
		if ($urandom_range(0, 2) == 0)
			write_reg(REG_SPARE_FIRST + IDX_W'($urandom_range(0, 2)), $urandom);
	endtask

	task automatic run_directed();
		// friction exactly cancels the speed
		send_frame(mk_frame(32'sh000A_0000, '0, '0, 1'b1, 16'h8000, '0, '0, '0));
		settle();
		write_reg(pmes_pkg::REG_FRICTION_SCALE, 32'h000A_0000);
		send_frame(mk_frame('0, '0, '0, 1'b1, 16'h8000, '0, '0, '0));
		send_frame(mk_frame('0, '0, '0, 1'b1, 16'h8000, '0, '0, '0));
		// partial decay, then overshoot stops at zero
		send_frame(mk_frame(32'sh000A_0000, '0, '0, 1'b1, 16'h8000, 32'sh10, '0, '0));
		send_frame(mk_frame('0, '0, '0, 1'b1, 16'h1000, '0, '0, '0));
		send_frame(mk_frame('0, '0, '0, 1'b1, 16'hFFFF, '0, '0, '0));
		send_frame(mk_frame(-32'sh000A_0000, '0, '0, 1'b1, 16'h8000, '0, '0, '0));
		send_frame(mk_frame('0, '0, '0, 1'b1, 16'h1000, '0, '0, '0));
		// any force blocks friction
		send_frame(mk_frame('0, '0, 32'sd1, 1'b1, 16'h1000, '0, '0, '0));
		send_frame(mk_frame('0, -32'sd1, '0, 1'b1, 16'hFFFF, '0, '0, '0));
		// fall-speed clamp, then speed sitting at the limit
		send_frame(mk_frame('0, '0, '0, 1'b0, 16'hFFFF, '0, '0, '0));
		send_frame(mk_frame('0, '0, '0, 1'b0, 16'h0000, '0, '0, '0));
		send_frame(mk_frame('0, 32'sh7FFF_FFFF, '0, 1'b0, 16'hFFFF, '0, '0, '0));
		send_frame(mk_frame(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 16'hFFFF,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
		send_frame(mk_frame(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 16'hFFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000));
		settle();
		write_reg(pmes_pkg::REG_USE_GRAVITY, 32'hFFFF_FFFE);
		write_reg(pmes_pkg::REG_INVERSE_MASS, 32'hFFFF_FFFF);
		write_reg(pmes_pkg::REG_GRAVITY_Y, 32'h8000_0000);
		write_reg(pmes_pkg::REG_MAX_FALL_SPEED, 32'hFFFF_FFFF);
		write_reg(pmes_pkg::REG_FRICTION_SCALE, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_FIRST, 32'h0000_0001);
		write_reg(REG_SPARE_LAST, 32'hFFFF_FFFF);
		// gravity off: force acts on y in the air and on ground
		send_frame(mk_frame('0, 32'sd1, '0, 1'b0, 16'hFFFF, '0, '0, '0));
		send_frame(mk_frame('0, -32'sh0001_0000, '0, 1'b1, 16'h8000, '0, '0, '0));
		send_frame(mk_frame('0, '0, '0, 1'b1, 16'hFFFF, '0, '0, '0));
		send_frame(mk_frame(-32'sd1, '0, '0, 1'b0, 16'h0001, 32'sh0000_1234, '0, '0));
		settle();
		write_reg(pmes_pkg::REG_USE_GRAVITY, 32'h0000_0001);
		write_reg(pmes_pkg::REG_GRAVITY_Y, 32'h7FFF_FFFF);
		write_reg(pmes_pkg::REG_MAX_FALL_SPEED, 32'h0000_0000);
		write_reg(pmes_pkg::REG_INVERSE_MASS, 32'h0000_0000);
		write_reg(pmes_pkg::REG_FRICTION_SCALE, 32'h0000_0000);
		send_frame(mk_frame('0, '0, '0, 1'b0, 16'hFFFF, '0, '0, '0));
		send_frame(mk_frame(32'sh7FFF_FFFF, '0, '0, 1'b1, 16'hFFFF, '0, '0, '0));
		send_frame(mk_frame('0, 32'sh8000_0000, '0, 1'b0, 16'h0001, '0, '0, '0));
		settle();
	endtask

	// result side: random stalls, plus a long hold-off on request
	initial begin
		int unsigned  w;
		step_result_t got;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (snk_hold != 0) begin
				result_ch.ready <= 1'b0;
				repeat (snk_hold) @(posedge clk);
				snk_hold = 0;
			end
			w = snk_idle ? $urandom_range(0, 14) : 0;
			if (w != 0) begin
				result_ch.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
			got.pos_x = result_ch.pos_x_out;
			got.pos_y = result_ch.pos_y_out;
			got.pos_z = result_ch.pos_z_out;
			got.vel_x = result_ch.vel_x_out;
			got.vel_y = result_ch.vel_y_out;
			got.vel_z = result_ch.vel_z_out;
			sb.check_step(got);
		end
	end

	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		frame_ch.valid      = 1'b0;
		frame_ch.force_x    = '0;
		frame_ch.force_y    = '0;
		frame_ch.force_z    = '0;
		frame_ch.on_ground  = 1'b0;
		frame_ch.frame_time = '0;
		frame_ch.pos_x_in   = '0;
		frame_ch.pos_y_in   = '0;
		frame_ch.pos_z_in   = '0;
		src_idle            = 1'b1;
		snk_idle            = 1'b1;
		snk_hold            = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < 8; p++) begin
			settle();
			shuffle_settings();
			src_idle = 1'($urandom_range(0, 1));
			snk_idle = 1'($urandom_range(0, 1));
			// sink stalls while the source keeps pushing items
			if (p == 2) begin
				src_idle = 1'b0;
				snk_hold = 300;
			end
			for (int i = 0; i < 110; i++)
				send_frame(rand_frame());
		end
		settle();
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_steps.size() == 0)
			$display("point_mass_euler_step_core verification clean");
		else
			$display("point_mass_euler_step_core verification failed");
		$finish;
	end

endmodule

[files.f]
rtl/pmes_pkg.sv
rtl/pmes_if.sv
rtl/pmes_cfg.sv
rtl/pmes_mul.sv
rtl/pmes_dp.sv
rtl/pmes_ctrl.sv
rtl/point_mass_euler_step_core.sv
tb/tb_top.sv
